// File: rtl/ufd_pkg.sv
// shared types and constants for the utf-8 to utf-16 decoder
`default_nettype none

package ufd_pkg;

  localparam int UNIT_W      = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [UNIT_W-1:0] REPL_UNIT  = 21'h00FFFD;
  localparam logic [UNIT_W-1:0] SUPP_BASE  = 21'h010000;
  localparam logic [UNIT_W-1:0] HIGH_BASE  = 21'h00D800;
  localparam logic [UNIT_W-1:0] LOW_BASE   = 21'h00DC00;

  // what the middle part of a command emits
  typedef enum logic [1:0] {
    MAIN_NONE,
    MAIN_CP,
    MAIN_PAIR,
    MAIN_REPL
  } main_kind_t;

  // one decoded byte: pre replacements, a main item, post replacements
  typedef struct packed {
    logic              eos;
    logic [1:0]        post;
    main_kind_t        kind;
    logic [1:0]        pre;
    logic [UNIT_W-1:0] cp;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/ufd_front.sv
// front end: takes utf-8 bytes, tracks the open sequence and issues commands
`default_nettype none

module ufd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    byte_in,
  input  wire logic          end_of_string,
  input  wire logic          wide_units,
  input  wire logic          queue_full,
  output logic               push,
  output ufd_pkg::cmd_t      cmd
);

  logic [ufd_pkg::UNIT_W-1:0] partial;
  logic [ufd_pkg::UNIT_W-1:0] partial_next;
  logic [1:0]                 needed;
  logic [1:0]                 needed_next;
  logic [1:0]                 held;
  logic [1:0]                 held_next;
  logic                       accept;
  logic                       is_cont;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (byte_in[7:6] == 2'b10);

  always_comb begin
    partial_next = partial;
    needed_next  = needed;
    held_next    = held;
    cmd          = '0;
    cmd.kind     = ufd_pkg::MAIN_NONE;
    cmd.eos      = end_of_string;
    if (needed != 2'd0 && is_cont) begin
      partial_next = {partial[ufd_pkg::UNIT_W-7:0], byte_in[5:0]};
      needed_next  = needed - 2'd1;
      held_next    = held + 2'd1;
      if (needed_next == 2'd0) begin
        cmd.kind     = ufd_pkg::MAIN_CP;
        cmd.cp       = partial_next;
        partial_next = '0;
        held_next    = 2'd0;
      end
    end else begin
      if (needed != 2'd0) begin
        // broken sequence: one replacement per held byte, then a fresh lead
        cmd.pre      = held;
        partial_next = '0;
        needed_next  = 2'd0;
        held_next    = 2'd0;
      end
      priority if (byte_in[7] == 1'b0) begin
        cmd.kind = ufd_pkg::MAIN_CP;
        cmd.cp   = {13'd0, byte_in};
      end else if (byte_in[7:5] == 3'b110) begin
        partial_next = {16'd0, byte_in[4:0]};
        needed_next  = 2'd1;
        held_next    = 2'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
        partial_next = {17'd0, byte_in[3:0]};
        needed_next  = 2'd2;
        held_next    = 2'd1;
      end else if (byte_in[7:3] == 5'b11110) begin
        partial_next = {18'd0, byte_in[2:0]};
        needed_next  = 2'd3;
        held_next    = 2'd1;
      end else begin
        cmd.kind = ufd_pkg::MAIN_REPL;
        cmd.cp   = ufd_pkg::REPL_UNIT;
      end
    end
    if (cmd.kind == ufd_pkg::MAIN_CP && !wide_units && (cmd.cp[20:16] != 5'd0)) begin
      cmd.kind = ufd_pkg::MAIN_PAIR;
    end
    // incomplete sequence at end of string
    if (end_of_string) begin
      if (needed_next != 2'd0) begin
        cmd.post = held_next;
      end
      partial_next = '0;
      needed_next  = 2'd0;
      held_next    = 2'd0;
    end
  end

  assign push = accept &&
                (cmd.pre != 2'd0 || cmd.kind != ufd_pkg::MAIN_NONE || cmd.post != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      needed  <= 2'd0;
      held    <= 2'd0;
    end else if (accept) begin
      partial <= partial_next;
      needed  <= needed_next;
      held    <= held_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ufd_queue.sv
// small flop queue of commands between front and back end
`default_nettype none

module ufd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  ufd_pkg::cmd_t      push_cmd,
  input  wire logic          pop,
  output ufd_pkg::cmd_t      head,
  output logic               not_empty,
  output logic               full
);

  ufd_pkg::cmd_t                entries [ufd_pkg::QUEUE_DEPTH];
  logic [ufd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ufd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ufd_pkg::QCNT_W-1:0]   count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == ufd_pkg::QCNT_W'(ufd_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("command pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("command popped from empty queue");

endmodule

`default_nettype wire

// File: rtl/ufd_back.sv
// back end: expands each command into output words, one per cycle unless the output stalls
`default_nettype none

module ufd_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  ufd_pkg::cmd_t                    head,
  input  wire logic                        head_valid,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ufd_pkg::UNIT_W-1:0]       out_unit,
  output logic                             out_repl,
  output logic                             out_run_last,
  output logic                             out_done
);

  logic [1:0]                  idx;
  logic [3:0]                  pos;
  logic [3:0]                  pre_w;
  logic [3:0]                  main_n;
  logic [3:0]                  main_end;
  logic [3:0]                  total;
  logic                        load;
  logic                        is_last;
  logic [ufd_pkg::UNIT_W-1:0]  supp;
  logic [ufd_pkg::UNIT_W-1:0]  unit_sel;
  logic                        repl_sel;

  assign supp  = head.cp - ufd_pkg::SUPP_BASE;
  assign pos   = {2'd0, idx};
  assign pre_w = {2'd0, head.pre};

  always_comb begin
    unique case (head.kind)
      ufd_pkg::MAIN_NONE: main_n = 4'd0;
      ufd_pkg::MAIN_PAIR: main_n = 4'd2;
      default:            main_n = 4'd1;
    endcase
  end

  assign main_end = pre_w + main_n;
  assign total    = main_end + {2'd0, head.post};
  assign is_last  = (pos == total - 4'd1);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && is_last;

  always_comb begin
    unit_sel = ufd_pkg::REPL_UNIT;
    repl_sel = 1'b1;
    if (pos >= pre_w && pos < main_end) begin
      unique case (head.kind)
        ufd_pkg::MAIN_CP: begin
          unit_sel = head.cp;
          repl_sel = 1'b0;
        end
        ufd_pkg::MAIN_PAIR: begin
          repl_sel = 1'b0;
          if (pos == pre_w) begin
            unit_sel = ufd_pkg::HIGH_BASE + {10'd0, supp[20:10]};
          end else begin
            unit_sel = ufd_pkg::LOW_BASE + {11'd0, supp[9:0]};
          end
        end
        default: begin
          unit_sel = ufd_pkg::REPL_UNIT;
          repl_sel = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_unit     <= unit_sel;
      out_repl     <= repl_sel;
      out_run_last <= is_last;
      out_done     <= is_last && head.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_done_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> out_run_last)
    else $error("string end on a word that does not close its byte");

  a_idx_resets_after_pop: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == 2'd0))
    else $error("word index not cleared after command completes");

endmodule

`default_nettype wire

// File: rtl/utf8_to_utf16_decoder_unit.sv
// top level of the utf-8 to utf-16 decoder
`default_nettype none

// Decodes a UTF-8 byte stream into UTF-16 code units, or whole code points
// when wide_units (cfg_data[0]) is set. One byte is accepted per cycle while
// the four-entry command queue between the front and back end has room. The
// back end sends one word per cycle unless the output stalls; a byte yields no
// words while a sequence is open, one for an ASCII byte and up to four for
// errors and surrogate pairs, and the output word register is the only rate
// limit. A byte's command passes through the queue into the output word
// register. No overlong, surrogate or range checks are made; bad input gives
// U+FFFD words flagged in tuser. Write the configuration only while idle.
module utf8_to_utf16_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,       // wide_units
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // byte_in
  input  wire logic        s_axis_tlast,   // end_of_string
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // unit[20:0], zero pad
  output logic [1:0]       m_axis_tuser,   // is_replacement, string_done
  output logic             m_axis_tlast    // run_last
);

  logic                       wide_units;
  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_not_empty;
  ufd_pkg::cmd_t              front_cmd;
  ufd_pkg::cmd_t              head_cmd;
  logic [ufd_pkg::UNIT_W-1:0] unit;
  logic                       repl;
  logic                       done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_units <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wide_units <= cfg_data;
    end
  end

  ufd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .byte_in       (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .wide_units    (wide_units),
    .queue_full    (q_full),
    .push          (push),
    .cmd           (front_cmd)
  );

  ufd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ufd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_cmd),
    .head_valid   (q_not_empty),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_unit     (unit),
    .out_repl     (repl),
    .out_run_last (m_axis_tlast),
    .out_done     (done)
  );

  assign m_axis_tdata = {3'd0, unit};
  assign m_axis_tuser = {done, repl};

endmodule

`default_nettype wire
